@@ hdl/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher package
// Shared payload types, constants and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package sha1_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } t_in_req;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_req;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_FILL = 6'd56;
    localparam int          ROUNDS = 80;
    localparam int          DIGEST_WORDS = 5;

    // Controller to datapath commands
    typedef struct packed {
        logic       put;        // write put_byte at fill position
        logic [7:0] put_byte;
        logic       cnt_byte;   // bump the message length
        logic       put_len;    // write length into words 14/15
        logic       comp_start; // load a..e from chaining words
        logic       comp_round; // run one round
        logic       comp_end;   // add a..e into chaining words
        logic       reseed;     // reset chaining, fill and length
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [5:0] fill;
        logic [6:0] round;
    } t_sts;

endpackage

@@ hdl/sha1_datapath.sv @@
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Block buffer, message schedule, round unit, chaining words and length.
// ----------------------------------------------------------------------------
module sha1_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha1_pkg::t_cmd       i_cmd,
    input  logic [2:0]           i_rd_idx,
    output sha1_pkg::t_sts       o_sts,
    output logic [31:0]          o_rd_word
);
    logic [31:0] r_w [16];
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [5:0]  r_fill;
    logic [60:0] r_total;
    logic [6:0]  r_round;

    logic [3:0]  slot;
    logic [31:0] w_raw, w_cur, f, kc, t;
    logic [3:0]  widx;
    logic [4:0]  shamt;
    logic [31:0] merged;
    logic [63:0] bits;

    assign slot  = r_round[3:0];
    assign w_raw = r_w[slot + 4'd13] ^ r_w[slot + 4'd8] ^ r_w[slot + 4'd2] ^ r_w[slot];
    assign w_cur = (r_round >= 7'd16) ? {w_raw[30:0], w_raw[31]} : r_w[slot];
    assign bits  = {r_total, 3'b000};
    assign widx  = r_fill[5:2];
    assign shamt = {~r_fill[1:0], 3'b000};

    // Round function and constant select
    always_comb begin
        if (r_round < 7'd20) begin
            f  = (r_b & r_c) | (~r_b & r_d);
            kc = 32'h5a827999;
        end else if (r_round < 7'd40) begin
            f  = r_b ^ r_c ^ r_d;
            kc = 32'h6ed9eba1;
        end else if (r_round < 7'd60) begin
            f  = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            kc = 32'h8f1bbcdc;
        end else begin
            f  = r_b ^ r_c ^ r_d;
            kc = 32'hca62c1d6;
        end
        t = {r_a[26:0], r_a[31:27]} + f + r_e + kc + w_cur;
    end

    // Byte merge into current word
    always_comb begin
        merged = (r_fill[1:0] == 2'd0) ? 32'd0 : r_w[widx];
        merged = merged | ({24'd0, i_cmd.put_byte} << shamt);
    end

    // Block buffer and schedule
    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_w[widx] <= merged;
        end else if (i_cmd.put_len) begin
            r_w[14] <= bits[63:32];
            r_w[15] <= bits[31:0];
        end else if (i_cmd.comp_round) begin
            r_w[slot] <= w_cur;
        end
    end

    // Working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_start) begin
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3]; r_e <= r_h[4];
        end else if (i_cmd.comp_round) begin
            r_e <= r_d; r_d <= r_c; r_c <= {r_b[1:0], r_b[31:2]}; r_b <= r_a; r_a <= t;
        end
    end

    // Control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reseed) begin
            r_h[0] <= sha1_pkg::H0; r_h[1] <= sha1_pkg::H1; r_h[2] <= sha1_pkg::H2;
            r_h[3] <= sha1_pkg::H3; r_h[4] <= sha1_pkg::H4;
            r_fill  <= '0;
            r_total <= '0;
            r_round <= '0;
        end else begin
            if (i_cmd.put)
                r_fill <= r_fill + 6'd1;
            if (i_cmd.cnt_byte)
                r_total <= r_total + 61'd1;
            if (i_cmd.comp_start)
                r_round <= '0;
            else if (i_cmd.comp_round)
                r_round <= r_round + 7'd1;
            if (i_cmd.comp_end) begin
                r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b; r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d; r_h[4] <= r_h[4] + r_e;
                r_round <= '0;
            end
        end
    end

    assign o_sts       = '{fill: r_fill, round: r_round};
    assign o_rd_word   = r_h[i_rd_idx];

endmodule

@@ hdl/sha1_ctrl.sv @@
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte writes, padding, compressions and digest output.
// ----------------------------------------------------------------------------
module sha1_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sha1_pkg::t_in_req    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_rd_idx,
    output logic                 o_last,
    input  sha1_pkg::t_sts       i_sts,
    output sha1_pkg::t_cmd       o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_COMP  = 3'd1;  // rounds running
    localparam logic [2:0] S_FIN   = 3'd2;  // add into chaining words
    localparam logic [2:0] S_PAD   = 3'd3;  // pad bytes
    localparam logic [2:0] S_LEN   = 3'd4;  // length words
    localparam logic [2:0] S_OUT   = 3'd5;  // digest words

    logic [2:0] r_state, n_state;
    logic       r_end, n_end;   // message end pending
    logic       r_padded, n_padded; // 0x80 written
    logic       r_final, n_final;   // running last block
    logic [2:0] r_idx, n_idx;
    logic       acc;

    assign acc        = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_rd_idx   = r_idx;
    assign o_last     = (r_idx == 3'(sha1_pkg::DIGEST_WORDS - 1));

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_end    = r_end;
        n_padded = r_padded;
        n_final  = r_final;
        n_idx    = r_idx;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.put      = i_in_data.byte_present;
                    o_cmd.put_byte = i_in_data.data_byte;
                    o_cmd.cnt_byte = i_in_data.byte_present;
                    n_end    = i_in_data.message_end;
                    n_padded = 1'b0;
                    n_final  = 1'b0;
                    if (i_in_data.byte_present && i_sts.fill == 6'd63) begin
                        o_cmd.comp_start = 1'b1;
                        n_state = S_COMP;
                    end else if (i_in_data.message_end) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_COMP: begin
                o_cmd.comp_round = 1'b1;
                if (i_sts.round == 7'(sha1_pkg::ROUNDS - 1))
                    n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.comp_end = 1'b1;
                if (r_final) begin
                    n_idx   = '0;
                    n_state = S_OUT;
                end else if (r_end) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                if (r_padded && i_sts.fill == sha1_pkg::LEN_FILL) begin
                    n_state = S_LEN;
                end else begin
                    o_cmd.put      = 1'b1;
                    o_cmd.put_byte = r_padded ? 8'd0 : sha1_pkg::PAD_BYTE;
                    n_padded       = 1'b1;
                    if (i_sts.fill == 6'd63) begin
                        o_cmd.comp_start = 1'b1;
                        n_state = S_COMP;
                    end
                end
            end
            S_LEN: begin
                o_cmd.put_len    = 1'b1;
                o_cmd.comp_start = 1'b1;
                n_final = 1'b1;
                n_state = S_COMP;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (o_last) begin
                        o_cmd.reseed = 1'b1;
                        n_idx   = '0;
                        n_end   = 1'b0;
                        n_final = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_end    <= 1'b0;
            r_padded <= 1'b0;
            r_final  <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_end    <= n_end;
            r_padded <= n_padded;
            r_final  <= n_final;
            r_idx    <= n_idx;
        end
    end

    // Checks
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_idx <= 3'd4) else $error("digest index out of range");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> !o_in_ready) else $error("accept during compression");
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> i_sts.round < 7'd80) else $error("round overflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(r_idx))
        else $error("digest dropped");

endmodule

@@ hdl/sha1_byte_stream_hasher_unit.sv @@
// Throughput: one request per cycle while no block fills up and no message ends.
// Block fill: the 64th byte of a block holds the input through the 80 rounds,
// one per cycle, then the add-back; the load shares the accept cycle.
// Message end: up to 64 pad bytes, a check and the length write, one or two
// compressions, then five digest words, one per cycle as taken.
// Reset (sync, active low) loads the SHA-1 seed words and clears the length.
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher top level
// Joins the controller and the datapath; drives the digest from the chaining words.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sha1_pkg::t_in_req     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sha1_pkg::t_out_req    o_out_data
);
    sha1_pkg::t_cmd cmd;
    sha1_pkg::t_sts sts;
    logic [2:0]     rd_idx;
    logic [31:0]    rd_word;
    logic           last;

    sha1_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_rd_idx   (rd_idx),
        .o_last     (last),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sha1_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_rd_idx (rd_idx),
        .o_sts    (sts),
        .o_rd_word(rd_word)
    );

    assign o_out_data = '{digest_word: rd_word, word_index: rd_idx, last_word: last};

endmodule
